>>> rtl/lpmc_pkg.sv
// Shared types, register codes and constants for the LED pattern mode controller.
`default_nettype none
package lpmc_pkg;

    // Default LED count.
    localparam int LED_COUNT_DEF = 8;

    // Configuration port widths and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_REPRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST    = 2'd2;

    // Register reset values.
    localparam logic [5:0] REPRESS_RST = 6'd50;
    localparam logic [9:0] SLOW_RST    = 10'd1000;
    localparam logic [9:0] FAST_RST    = 10'd500;

    // Modes.
    localparam logic [1:0] MODE_BOUNCE  = 2'd0;
    localparam logic [1:0] MODE_INVERSE = 2'd1;
    localparam logic [1:0] MODE_SPARKLE = 2'd2;
    localparam logic [1:0] MODE_DARK    = 2'd3;

    // Sparkle phases.
    localparam logic [1:0] PH_NEW  = 2'd0;
    localparam logic [1:0] PH_SHOW = 2'd1;
    localparam logic [1:0] PH_OFF  = 2'd2;

    // Button that toggles the speed.
    localparam logic [1:0] BTN_SPEED = 2'd0;

    // Press age saturation.
    localparam logic [5:0] AGE_MAX = 6'd63;

    // Sparkle delay draws: base + rnd mod divisor.
    localparam int DELAY_W    = 11;
    localparam int DISP_MOD   = 1401;
    localparam int GAP_MOD    = 51;
    localparam int DELAY_BASE = 100;

    // Reciprocals: q = (rnd * RECIP) >> SHIFT is exact for any 16-bit rnd.
    localparam int DISP_RECIP = 47901;
    localparam int DISP_SHIFT = 26;
    localparam int GAP_RECIP  = 82242;
    localparam int GAP_SHIFT  = 22;
    localparam int DISP_Q_W   = 6;
    localparam int GAP_Q_W    = 11;

    typedef struct packed {
        logic [5:0] repress_interval_ms;
        logic [9:0] slow_period_ms;
        logic [9:0] fast_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  buttons_low;
        logic [7:0]  random_pattern;
        logic [15:0] random_value;
    } tick_item_t;

    typedef struct packed {
        logic [7:0] led_levels;
        logic [1:0] active_mode;
        logic       fast_speed;
        logic [1:0] sparkle_phase;
    } result_item_t;

    // Delays drawn for this tick, both already offset by the base.
    typedef struct packed {
        logic [DELAY_W-1:0] show_delay;
        logic [DELAY_W-1:0] gap_delay;
    } draw_t;

endpackage
`default_nettype wire

>>> rtl/lpmc_cfg.sv
// Configuration register file for the LED pattern mode controller.
`default_nettype none
module lpmc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lpmc_pkg::CFG_DATA_W-1:0] cfg_data,
    output lpmc_pkg::cfg_t                     cfg
);

    lpmc_pkg::cfg_t cfg_reg;

    // Write decode; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repress_interval_ms <= lpmc_pkg::REPRESS_RST;
            cfg_reg.slow_period_ms      <= lpmc_pkg::SLOW_RST;
            cfg_reg.fast_period_ms      <= lpmc_pkg::FAST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpmc_pkg::CFG_REPRESS: cfg_reg.repress_interval_ms <= cfg_data[5:0];
                lpmc_pkg::CFG_SLOW:    cfg_reg.slow_period_ms      <= cfg_data[9:0];
                lpmc_pkg::CFG_FAST:    cfg_reg.fast_period_ms      <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/lpmc_mode_core.sv
// Mode state and per-tick update: buttons, period counter, bounce and sparkle.
`default_nettype none
module lpmc_mode_core #(
    parameter int LED_COUNT = lpmc_pkg::LED_COUNT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  lpmc_pkg::cfg_t            cfg,
    input  wire logic [3:0]           buttons_low,
    input  wire logic [7:0]           random_pattern,
    input  lpmc_pkg::draw_t           draw,
    output lpmc_pkg::result_item_t    result_next
);

    localparam int POS_W = $clog2(LED_COUNT);
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(LED_COUNT - 1);
    localparam logic [LED_COUNT-1:0] ONE_LED = LED_COUNT'(1);

    // State
    logic [1:0]                  mode_reg, mode_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic                        down_reg, down_next;
    logic                        fast_reg, fast_next;
    logic [9:0]                  count_reg, count_next;
    logic [5:0]                  age_reg [4];
    logic [5:0]                  age_next [4];
    logic [1:0]                  phase_reg, phase_next;
    logic [LED_COUNT-1:0]        lit_reg, lit_next;
    logic [lpmc_pkg::DELAY_W-1:0] delay_reg, delay_next;
    logic [LED_COUNT-1:0]        led_reg, led_next;

    // Combinational helpers
    logic [3:0]                  pressed;
    logic                        btn_found;
    logic [1:0]                  btn_sel;
    logic                        btn_hit;
    logic                        restart;
    logic                        step;
    logic [9:0]                  period;
    logic [10:0]                 count_inc;
    logic [lpmc_pkg::DELAY_W-1:0] delay_dec;
    logic [LED_COUNT-1:0]        lowest;
    logic [LED_COUNT+7:0]        pattern_wide;
    logic [LED_COUNT-1:0]        pattern_n;
    logic [LED_COUNT+7:0]        led_wide;

    assign pressed      = ~buttons_low;
    assign pattern_wide = {{LED_COUNT{1'b0}}, random_pattern};
    assign pattern_n    = pattern_wide[LED_COUNT-1:0];

    // Lowest pressed button wins
    always_comb
    begin
        btn_found = 1'b0;
        btn_sel   = 2'd0;
        for (int b = 3; b >= 0; b--)
        begin
            if (pressed[b])
            begin
                btn_found = 1'b1;
                btn_sel   = 2'(b);
            end
        end
    end

    // Next-state logic for one tick
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            age_next[i] = (age_reg[i] != lpmc_pkg::AGE_MAX) ? age_reg[i] + 6'd1 : age_reg[i];
        end
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        down_next  = down_reg;
        fast_next  = fast_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        lit_next   = lit_reg;
        delay_next = delay_reg;
        led_next   = led_reg;
        restart    = 1'b0;
        step       = 1'b0;
        delay_dec  = '0;
        lowest     = '0;

        // Button handling
        btn_hit = btn_found && (age_next[btn_sel] >= cfg.repress_interval_ms);
        if (btn_hit)
        begin
            age_next[btn_sel] = 6'd0;
            if (btn_sel == lpmc_pkg::BTN_SPEED)
            begin
                fast_next  = ~fast_reg;
                count_next = 10'd0;
                restart    = 1'b1;
            end
            else
            begin
                mode_next  = btn_sel - 2'd1;
                led_next   = '0;
                pos_next   = '0;
                down_next  = 1'b0;
                phase_next = lpmc_pkg::PH_NEW;
                lit_next   = '0;
            end
        end

        // Period counter and mode step
        period    = fast_next ? cfg.fast_period_ms : cfg.slow_period_ms;
        count_inc = {1'b0, count_reg} + 11'd1;
        if (!restart)
        begin
            if (count_inc >= {1'b0, period})
            begin
                count_next = 10'd0;
                case (mode_next)
                    lpmc_pkg::MODE_BOUNCE:
                    begin
                        led_next = ONE_LED << pos_next;
                        step     = 1'b1;
                    end
                    lpmc_pkg::MODE_INVERSE:
                    begin
                        led_next = ~(ONE_LED << pos_next);
                        step     = 1'b1;
                    end
                    lpmc_pkg::MODE_DARK:
                    begin
                        led_next = '0;
                    end
                    default: ;
                endcase
            end
            else
            begin
                count_next = count_inc[9:0];
            end
        end

        // Bounce walk: turn at the ends, then move one place
        if (step)
        begin
            if (pos_next >= POS_TOP)
            begin
                down_next = 1'b1;
            end
            else if (pos_next == '0)
            begin
                down_next = 1'b0;
            end
            pos_next = down_next ? pos_next - POS_W'(1) : pos_next + POS_W'(1);
        end

        // Sparkle machine
        if (mode_next == lpmc_pkg::MODE_SPARKLE)
        begin
            delay_dec = (delay_next != '0) ? delay_next - 11'd1 : delay_next;
            lowest    = lit_next & (~lit_next + ONE_LED);
            case (phase_next)
                lpmc_pkg::PH_NEW:
                begin
                    lit_next   = pattern_n;
                    led_next   = led_next | pattern_n;
                    delay_next = draw.show_delay;
                    phase_next = lpmc_pkg::PH_SHOW;
                end
                lpmc_pkg::PH_SHOW:
                begin
                    if (delay_dec == '0)
                    begin
                        phase_next = lpmc_pkg::PH_OFF;
                        delay_next = draw.gap_delay;
                    end
                    else
                    begin
                        delay_next = delay_dec;
                    end
                end
                lpmc_pkg::PH_OFF:
                begin
                    if (delay_dec == '0)
                    begin
                        led_next   = led_next & ~lowest;
                        lit_next   = lit_next & ~lowest;
                        delay_next = draw.gap_delay;
                    end
                    else
                    begin
                        delay_next = delay_dec;
                    end
                    if (lit_next == '0)
                    begin
                        phase_next = lpmc_pkg::PH_NEW;
                    end
                end
                default:
                begin
                    phase_next = lpmc_pkg::PH_NEW;
                end
            endcase
        end
    end

    // State registers, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lpmc_pkg::MODE_DARK;
            pos_reg   <= '0;
            down_reg  <= 1'b0;
            fast_reg  <= 1'b0;
            count_reg <= 10'd0;
            for (int i = 0; i < 4; i++)
            begin
                age_reg[i] <= 6'd0;
            end
            phase_reg <= lpmc_pkg::PH_NEW;
            lit_reg   <= '0;
            delay_reg <= '0;
            led_reg   <= '0;
        end
        else if (en)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            down_reg  <= down_next;
            fast_reg  <= fast_next;
            count_reg <= count_next;
            for (int i = 0; i < 4; i++)
            begin
                age_reg[i] <= age_next[i];
            end
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            delay_reg <= delay_next;
            led_reg   <= led_next;
        end
    end

    // Result from the updated state; LEDs beyond eight are not reported
    assign led_wide = {8'd0, led_next};
    assign result_next.led_levels    = led_wide[7:0];
    assign result_next.active_mode   = mode_next;
    assign result_next.fast_speed    = fast_next;
    assign result_next.sparkle_phase = phase_next;

endmodule
`default_nettype wire

>>> rtl/led_pattern_mode_controller.sv
// Top level of the LED pattern mode controller: pipeline, delay draws and handshakes.
`default_nettype none
// One tick item (a millisecond: button levels and random bits) yields one result item
// holding the LED levels, mode, speed and sparkle phase after that tick. Items flow
// through three registers: the input register, a stage holding the reciprocal quotients
// of random_value by 1401 and 51, and the result register, which is loaded together
// with the mode state. One item is taken every clock as long as results are taken.
// The state update, done once per item in the last stage, sets the rate.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while no item is in flight, as the block does not enforce it.
// There is no clearing pass after reset. LED_COUNT (2..16) sets the number of LEDs;
// only the low eight appear on led_levels.
module led_pattern_mode_controller #(
    parameter int LED_COUNT = lpmc_pkg::LED_COUNT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lpmc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            tick_valid,
    output logic                                 tick_ready,
    input  lpmc_pkg::tick_item_t                 tick,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output lpmc_pkg::result_item_t               result
);

    lpmc_pkg::cfg_t         cfg;
    lpmc_pkg::draw_t        draw;
    lpmc_pkg::result_item_t result_next;

    // Pipeline registers
    logic                              s1_valid_reg;
    lpmc_pkg::tick_item_t              s1_item_reg;
    logic                              s2_valid_reg;
    logic [3:0]                        s2_buttons_reg;
    logic [7:0]                        s2_pattern_reg;
    logic [15:0]                       s2_rnd_reg;
    logic [lpmc_pkg::DISP_Q_W-1:0]     s2_qdisp_reg;
    logic [lpmc_pkg::GAP_Q_W-1:0]      s2_qgap_reg;
    logic                              out_valid_reg;
    lpmc_pkg::result_item_t            out_item_reg;

    // Handshake chain
    logic rdy1, rdy2, rdy3, move2;

    // Quotient and remainder arithmetic
    logic [31:0] disp_prod;
    logic [32:0] gap_prod;
    logic [16:0] disp_back, gap_back;
    logic [16:0] disp_rem_raw, gap_rem_raw;
    logic [16:0] disp_rem, gap_rem;

    assign rdy3  = !out_valid_reg || result_ready;
    assign move2 = s2_valid_reg && rdy3;
    assign rdy2  = !s2_valid_reg || rdy3;
    assign rdy1  = !s1_valid_reg || rdy2;
    assign tick_ready = rdy1;

    // Reciprocal multiplies on the input register
    assign disp_prod = 32'(s1_item_reg.random_value) * 32'(lpmc_pkg::DISP_RECIP);
    assign gap_prod  = 33'(s1_item_reg.random_value) * 33'(lpmc_pkg::GAP_RECIP);

    // Remainders from the registered quotients, with one safety correction
    always_comb
    begin
        disp_back    = 17'(s2_qdisp_reg) * 17'(lpmc_pkg::DISP_MOD);
        gap_back     = 17'(s2_qgap_reg) * 17'(lpmc_pkg::GAP_MOD);
        disp_rem_raw = {1'b0, s2_rnd_reg} - disp_back;
        gap_rem_raw  = {1'b0, s2_rnd_reg} - gap_back;
        disp_rem     = (disp_rem_raw >= 17'(lpmc_pkg::DISP_MOD))
                       ? disp_rem_raw - 17'(lpmc_pkg::DISP_MOD) : disp_rem_raw;
        gap_rem      = (gap_rem_raw >= 17'(lpmc_pkg::GAP_MOD))
                       ? gap_rem_raw - 17'(lpmc_pkg::GAP_MOD) : gap_rem_raw;
        draw.show_delay = disp_rem[lpmc_pkg::DELAY_W-1:0]
                          + lpmc_pkg::DELAY_W'(lpmc_pkg::DELAY_BASE);
        draw.gap_delay  = gap_rem[lpmc_pkg::DELAY_W-1:0]
                          + lpmc_pkg::DELAY_W'(lpmc_pkg::DELAY_BASE);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= tick_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tick_valid && rdy1)
        begin
            s1_item_reg <= tick;
        end
        if (s1_valid_reg && rdy2)
        begin
            s2_buttons_reg <= s1_item_reg.buttons_low;
            s2_pattern_reg <= s1_item_reg.random_pattern;
            s2_rnd_reg     <= s1_item_reg.random_value;
            s2_qdisp_reg   <= disp_prod[lpmc_pkg::DISP_SHIFT +: lpmc_pkg::DISP_Q_W];
            s2_qgap_reg    <= gap_prod[lpmc_pkg::GAP_SHIFT +: lpmc_pkg::GAP_Q_W];
        end
        if (move2)
        begin
            out_item_reg <= result_next;
        end
    end

    lpmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpmc_mode_core #(
        .LED_COUNT (LED_COUNT)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (move2),
        .cfg            (cfg),
        .buttons_low    (s2_buttons_reg),
        .random_pattern (s2_pattern_reg),
        .draw           (draw),
        .result_next    (result_next)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // An empty pipeline always takes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !s2_valid_reg && !out_valid_reg) |-> tick_ready)
        else $error("empty pipeline not ready");

    // A result only appears after an item sat in the quotient stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result without a source item");

    // Outside sparkle mode the sparkle phase rests at new pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result.active_mode != lpmc_pkg::MODE_SPARKLE)
        |-> (result.sparkle_phase == lpmc_pkg::PH_NEW))
        else $error("sparkle phase moved outside sparkle mode");

endmodule
`default_nettype wire
